[sv/hta_pkg.sv]
// shared types, constants and helpers of the handle table allocator
`default_nettype none

package hta_pkg;

   localparam int SLOTS  = 64;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int HANDLE_W = 32;

   localparam logic [HANDLE_W-1:0] FIRST_HANDLE_RESET = 32'd1;

   // request operation codes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FIND  = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   // index of the lowest set bit, zero when none is set
   function automatic logic [SLOT_W-1:0] low_index(input logic [SLOTS-1:0] vec);
      logic [SLOTS-1:0]  one;
      logic [SLOT_W-1:0] idx;
      one = vec & (~vec + SLOTS'(1));
      idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (one[i]) begin
            idx = idx | SLOT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

[sv/handle_table_allocator.sv]
// top level of the handle table allocator
//
// A request (req_operation, req_handle, req_slot) is taken at a rising edge
// with start high and busy low. Allocate claims the lowest free slot and
// gives it the current handle counter value; find returns the lowest busy
// slot holding req_handle; free releases req_slot.
// Timing: the accept cycle compares req_handle against all 64 slots in
// parallel; the next cycle (busy high) priority-encodes and updates the
// table. The result sits on the rsp_ ports for one cycle with rsp_strobe
// high, starting in the cycle after the busy cycle. busy drops in that
// same cycle, so a new request can already be taken while the result
// is shown; none is taken during the busy cycle of the request before.
// The receiver has no way to stall: each result beat is shown exactly once.
// csr_wdata loads the handle counter when csr_valid and csr_ready are high;
// csr_ready is high whenever busy is low.
// Reset (synchronous, active high) frees every slot, loads the counter
// with 1 and clears busy and rsp_strobe.
`default_nettype none

module handle_table_allocator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [1:0]                      req_operation,
   input  wire logic [hta_pkg::HANDLE_W-1:0]    req_handle,
   input  wire logic [hta_pkg::SLOT_W-1:0]      req_slot,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_status,
   output logic [hta_pkg::SLOT_W-1:0]           rsp_slot_index,
   output logic [hta_pkg::HANDLE_W-1:0]         rsp_handle_out,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [hta_pkg::HANDLE_W-1:0]    csr_wdata
);
   import hta_pkg::*;

   cmd_type cmd;

   assign csr_ready = ~busy;

   hta_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (cmd),
      .busy  (busy)
   );

   hta_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req_operation),
      .req_handle     (req_handle),
      .req_slot       (req_slot),
      .csr_write      (csr_valid && csr_ready),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_handle_out (rsp_handle_out)
   );

   // an accepted request holds busy for exactly one cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // the result beat follows the busy cycle and busy is gone by then
   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_strobe && !busy))
      else $error("missing result beat after busy cycle");

   // a result beat only ever comes from a busy cycle
   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a request");

   // failed requests carry zero index and handle
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STAT_OK)) |->
         (rsp_slot_index == '0 && rsp_handle_out == '0))
      else $error("failure result with nonzero payload");

endmodule

`default_nettype wire

[sv/hta_ctrl.sv]
// sequencer of the handle table allocator: capture then commit
`default_nettype none

module hta_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output hta_pkg::cmd_type     cmd,
   output logic                 busy
);
   import hta_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_COMMIT = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff == S_COMMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[sv/hta_dp.sv]
// slot table, handle counter, parallel compare and result registers
`default_nettype none

module hta_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire hta_pkg::cmd_type                cmd,
   input  wire logic [1:0]                      req_operation,
   input  wire logic [hta_pkg::HANDLE_W-1:0]    req_handle,
   input  wire logic [hta_pkg::SLOT_W-1:0]      req_slot,
   input  wire logic                            csr_write,
   input  wire logic [hta_pkg::HANDLE_W-1:0]    csr_wdata,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_status,
   output logic [hta_pkg::SLOT_W-1:0]           rsp_slot_index,
   output logic [hta_pkg::HANDLE_W-1:0]         rsp_handle_out
);
   import hta_pkg::*;

   logic [SLOTS-1:0]    slot_busy_ff;
   logic [HANDLE_W-1:0] slot_handle_ff [SLOTS];
   logic [HANDLE_W-1:0] counter_ff;

   logic [1:0]          op_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [SLOTS-1:0]    match_ff;
   logic [SLOTS-1:0]    match_in;

   logic                rsp_strobe_ff;
   logic [1:0]          status_ff;
   logic [SLOT_W-1:0]   index_ff;
   logic [HANDLE_W-1:0] handle_out_ff;

   logic [SLOTS-1:0]    free_vec;
   logic [SLOT_W-1:0]   alloc_idx;
   logic [SLOT_W-1:0]   find_idx;

   // compare every slot against the incoming handle in the accept cycle
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_in[i] = slot_busy_ff[i] && (slot_handle_ff[i] == req_handle);
      end
   end

   assign free_vec  = ~slot_busy_ff;
   assign alloc_idx = low_index(free_vec);
   assign find_idx  = low_index(match_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         handle_ff <= req_handle;
         slot_ff   <= req_slot;
         match_ff  <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_busy_ff  <= '0;
         counter_ff    <= FIRST_HANDLE_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.commit;
         if (csr_write) begin
            counter_ff <= csr_wdata;
         end
         if (cmd.commit) begin
            unique case (op_ff)
               OP_ALLOC: begin
                  if (|free_vec) begin
                     slot_busy_ff[alloc_idx] <= 1'b1;
                     counter_ff              <= counter_ff + HANDLE_W'(1);
                  end
               end
               OP_FREE: begin
                  slot_busy_ff[slot_ff] <= 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // handle entries only matter while the slot is marked busy
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         unique case (op_ff)
            OP_ALLOC: begin
               if (|free_vec) begin
                  slot_handle_ff[alloc_idx] <= counter_ff;
               end
            end
            OP_FREE: begin
               slot_handle_ff[slot_ff] <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         unique case (op_ff)
            OP_ALLOC: begin
               if (|free_vec) begin
                  status_ff     <= STAT_OK;
                  index_ff      <= alloc_idx;
                  handle_out_ff <= counter_ff;
               end else begin
                  status_ff     <= STAT_FULL;
                  index_ff      <= '0;
                  handle_out_ff <= '0;
               end
            end
            OP_FIND: begin
               if (|match_ff) begin
                  status_ff     <= STAT_OK;
                  index_ff      <= find_idx;
                  handle_out_ff <= handle_ff;
               end else begin
                  status_ff     <= STAT_NOT_FOUND;
                  index_ff      <= '0;
                  handle_out_ff <= '0;
               end
            end
            OP_FREE: begin
               status_ff     <= STAT_OK;
               index_ff      <= slot_ff;
               handle_out_ff <= '0;
            end
            default: begin
               status_ff     <= STAT_OK;
               index_ff      <= '0;
               handle_out_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_slot_index = index_ff;
   assign rsp_handle_out = handle_out_ff;

endmodule

`default_nettype wire
